@@ rtl/palette_gray_area_downscaler_unit_assert.svh @@
// assertion macros for the palette gray area downscaler
`ifndef PALETTE_GRAY_AREA_DOWNSCALER_UNIT_ASSERT_SVH
`define PALETTE_GRAY_AREA_DOWNSCALER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PGAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PGAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PGAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PGAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/pgad_pkg.sv @@
package pgad_pkg;

    localparam logic [23:0] PALETTE [128] = '{
        24'h000000, 24'h4a4a4a, 24'h6f6f6f, 24'h8e8e8e,
        24'haaaaaa, 24'hc0c0c0, 24'hd6d6d6, 24'hececec,
        24'h484800, 24'h69690f, 24'h86861d, 24'ha2a22a,
        24'hbbbb35, 24'hd2d240, 24'he8e84a, 24'hfcfc54,
        24'h7c2c00, 24'h904811, 24'ha26221, 24'hb47a30,
        24'hc3903d, 24'hd2a44a, 24'hdfb755, 24'hecc860,
        24'h901c00, 24'ha33915, 24'hb55328, 24'hc66c3a,
        24'hd5824a, 24'he39759, 24'hf0aa67, 24'hfcbc74,
        24'h940000, 24'ha71a1a, 24'hb83232, 24'hc84848,
        24'hd65c5c, 24'he46f6f, 24'hf08080, 24'hfc9090,
        24'h840064, 24'h97197a, 24'ha8308f, 24'hb846a2,
        24'hc659b3, 24'hd46cc3, 24'he07cd2, 24'hec8ce0,
        24'h500084, 24'h68199a, 24'h7d30ad, 24'h9246c0,
        24'ha459d0, 24'hb56ce0, 24'hc57cee, 24'hd48cfc,
        24'h140090, 24'h331aa3, 24'h4e32b5, 24'h6848c6,
        24'h7f5cd5, 24'h956fe3, 24'ha980f0, 24'hbc90fc,
        24'h000094, 24'h181aa7, 24'h2d32b8, 24'h4248c8,
        24'h545cd6, 24'h656fe4, 24'h7580f0, 24'h8490fc,
        24'h001c88, 24'h183b9d, 24'h2d57b0, 24'h4272c2,
        24'h548ad2, 24'h65a0e1, 24'h75b5ef, 24'h84c8fc,
        24'h003064, 24'h185080, 24'h2d6d98, 24'h4288b0,
        24'h54a0c5, 24'h65b7d9, 24'h75cceb, 24'h84e0fc,
        24'h004030, 24'h18624e, 24'h2d8169, 24'h429e82,
        24'h54b899, 24'h65d1ae, 24'h75e7c2, 24'h84fcd4,
        24'h004400, 24'h1a661a, 24'h328432, 24'h48a048,
        24'h5cba5c, 24'h6fd26f, 24'h80e880, 24'h90fc90,
        24'h143c00, 24'h355f18, 24'h527e2d, 24'h6e9c42,
        24'h87b754, 24'h9ed065, 24'hb4e775, 24'hc8fc84,
        24'h303800, 24'h505916, 24'h6d762b, 24'h88923e,
        24'ha0ab4f, 24'hb7c25f, 24'hccd86e, 24'he0ec7c,
        24'h482c00, 24'h694d14, 24'h866a26, 24'ha28638,
        24'hbb9f47, 24'hd2b656, 24'he8cc63, 24'hfce070
    };

    // reciprocal of 100 scaled by 2^19, exact for sums below 43690
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LUM,
        ST_SCALE,
        ST_MUL,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       clear_wr;
        logic       lum;
        logic       scale;
        logic       mul;
        logic       rd;
        logic       wr;
        logic       fin_rd;
        logic       div_load;
        logic       div_step;
        logic       emit;
        logic       advance;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic fs;
        logic beyond;
        logic sub_valid;
        logic finish;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/pgad_ram.sv @@
module pgad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/pgad_ctrl.sv @@
`include "palette_gray_area_downscaler_unit_assert.svh"

module pgad_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_first,
    output logic          o_in_ready,
    input  pgad_pkg::t_stat i_stat,
    output pgad_pkg::t_cmd  o_cmd
);
    import pgad_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = i_stat.fs ? ST_LUM : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_first) begin
                        n_state = ST_CLEAR;
                    end else if (!i_stat.beyond) begin
                        n_state = ST_LUM;
                    end
                end
            end
            ST_LUM: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_MUL;
                n_k     = '0;
            end
            ST_MUL: begin
                if (i_stat.sub_valid) begin
                    n_state = ST_RD;
                end else if (r_k == 2'd3) begin
                    n_state = ST_FIN;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (r_k == 2'd3) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MUL;
                    n_k     = r_k + 2'd1;
                end
            end
            ST_FIN: begin
                n_state = i_stat.finish ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.k      = r_k;
        o_cmd.accept = accept;
        case (r_state)
            ST_CLEAR: o_cmd.clear_wr = 1'b1;
            ST_LUM:   o_cmd.lum      = 1'b1;
            ST_SCALE: o_cmd.scale    = 1'b1;
            ST_MUL:   o_cmd.mul      = i_stat.sub_valid;
            ST_RD:    o_cmd.rd       = 1'b1;
            ST_WR:    o_cmd.wr       = 1'b1;
            ST_FIN: begin
                o_cmd.fin_rd  = i_stat.finish;
                o_cmd.advance = !i_stat.finish;
            end
            ST_LOAD:  o_cmd.div_load = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_EMIT: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.advance = i_stat.out_free;
            end
            default: o_cmd.accept = accept;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    `PGAD_ASSERT_NXT(a_first_clears, i_clk, i_rst_n, accept && i_in_first, r_state == ST_CLEAR)
    `PGAD_ASSERT_NXT(a_div_len, i_clk, i_rst_n, r_state == ST_DIV, r_state == ST_EMIT)
    `PGAD_ASSERT_NXT(a_fin_load, i_clk, i_rst_n, r_state == ST_FIN && i_stat.finish, r_state == ST_LOAD)
endmodule

@@ rtl/pgad_dp.sv @@
`include "palette_gray_area_downscaler_unit_assert.svh"

module pgad_dp #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 210,
    parameter int OUT_SIZE   = 84
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_code,
    input  logic            i_first,
    input  pgad_pkg::t_cmd  i_cmd,
    output pgad_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_gray,
    output logic [6:0]      o_row,
    output logic [6:0]      o_col,
    output logic            o_last
);
    import pgad_pkg::*;

    localparam int OW    = $clog2(OUT_SIZE + 1);
    localparam int AW    = $clog2(2 * OUT_SIZE);
    localparam int XW    = $clog2((OUT_SIZE + 1) * SRC_WIDTH + 1);
    localparam int YW    = $clog2((OUT_SIZE + 1) * SRC_HEIGHT + 1);
    localparam int YCW   = $clog2(SRC_HEIGHT + 1);
    localparam int DEN   = SRC_WIDTH * SRC_HEIGHT;
    localparam int ACC_W = $clog2(255 * DEN + 1);
    localparam int GW    = 8 + OW;
    localparam int PW    = 8 + 2 * OW;
    // reciprocal of the cell area, exact over the accumulator range
    localparam int DSH   = ACC_W + $clog2(DEN);
    localparam int RW    = ACC_W + 1;
    localparam int QW    = ACC_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << DSH) + 64'(DEN) - 64'd1) / 64'(DEN));

    logic [7:0]    r_code;
    logic          r_fs;
    logic [14:0]   r_sum;
    logic [7:0]    r_gray;
    logic [GW-1:0] r_goy;
    logic [PW-1:0] r_prod;
    logic [ACC_W-1:0] r_rem;
    logic [7:0]    r_quo;
    logic [AW-1:0] r_clr;

    logic [XW-1:0]  r_xo, n_xo, r_jb, n_jb;
    logic [YW-1:0]  r_yo, n_yo, r_ib, n_ib;
    logic [OW-1:0]  r_j0, n_j0, r_i0, n_i0;
    logic [YCW-1:0] r_y, n_y;

    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_ogray;
    logic [6:0]    r_orow, r_ocol;
    logic          r_olast;

    logic [XW-1:0] xe;
    logic [YW-1:0] ye;
    logic          col_two, row_two, col_fin, row_fin;
    logic [OW-1:0] ox, oy;
    logic [OW-1:0] col_k;
    logic          bank_k;
    logic [AW-1:0] addr_k, fin_addr, waddr, raddr;
    logic          col_ok, row_ok;
    logic [ACC_W-1:0] rdata, wdata;
    logic          we;
    logic [23:0]   rgb;
    logic [27:0]   scaled;
    logic [QW-1:0] quo_full;

    assign xe      = r_xo + XW'(OUT_SIZE);
    assign ye      = r_yo + YW'(OUT_SIZE);
    assign col_two = xe > r_jb;
    assign row_two = ye > r_ib;
    assign col_fin = xe >= r_jb;
    assign row_fin = ye >= r_ib;
    assign col_ok  = ({1'b0, r_j0} + (OW + 1)'(1)) < (OW + 1)'(OUT_SIZE);
    assign row_ok  = ({1'b0, r_i0} + (OW + 1)'(1)) < (OW + 1)'(OUT_SIZE);

    assign ox = i_cmd.k[0] ? OW'(xe - r_jb) : (col_two ? OW'(r_jb - r_xo) : OW'(OUT_SIZE));
    assign oy = i_cmd.k[1] ? OW'(ye - r_ib) : (row_two ? OW'(r_ib - r_yo) : OW'(OUT_SIZE));

    assign col_k    = r_j0 + OW'(i_cmd.k[0]);
    assign bank_k   = r_i0[0] ^ i_cmd.k[1];
    assign addr_k   = bank_k ? AW'(OUT_SIZE) + AW'(col_k) : AW'(col_k);
    assign fin_addr = r_i0[0] ? AW'(OUT_SIZE) + AW'(r_j0) : AW'(r_j0);

    assign we    = i_cmd.clear_wr || i_cmd.wr || i_cmd.emit;
    assign waddr = i_cmd.clear_wr ? r_clr : (i_cmd.emit ? fin_addr : addr_k);
    assign wdata = i_cmd.wr ? rdata + ACC_W'(r_prod) : '0;
    assign raddr = i_cmd.fin_rd ? fin_addr : addr_k;

    pgad_ram #(
        .WIDTH (ACC_W),
        .DEPTH (2 * OUT_SIZE)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rgb      = PALETTE[r_code[7:1]];
    assign scaled   = 28'(r_sum) * 28'(RECIP_100);
    assign quo_full = QW'(r_rem) * QW'(RECIP);

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_code <= i_code;
        end
        if (i_cmd.lum) begin
            r_sum <= r_code[0] ? '0 :
                     15'(rgb[23:16]) * 15'd21 + 15'(rgb[15:8]) * 15'd72 +
                     15'(rgb[7:0]) * 15'd7;
        end
        if (i_cmd.scale) begin
            r_gray <= scaled[RECIP_SHIFT +: 8];
        end
        if (i_cmd.mul) begin
            r_goy <= GW'(r_gray) * GW'(oy);
        end
        if (i_cmd.rd) begin
            r_prod <= PW'(r_goy) * PW'(ox);
        end
        if (i_cmd.div_load) begin
            r_rem <= rdata;
        end
        if (i_cmd.div_step) begin
            r_quo <= quo_full[DSH +: 8];
        end
        if (i_cmd.emit) begin
            r_ogray <= r_quo;
            r_orow  <= 7'(r_i0);
            r_ocol  <= 7'(r_j0);
            r_olast <= (r_i0 == OW'(OUT_SIZE - 1)) && (r_j0 == OW'(OUT_SIZE - 1));
        end
    end

    // position tracking
    always_comb begin
        n_xo = r_xo;
        n_jb = r_jb;
        n_j0 = r_j0;
        n_yo = r_yo;
        n_ib = r_ib;
        n_i0 = r_i0;
        n_y  = r_y;
        if (i_cmd.accept && i_first) begin
            n_xo = '0;
            n_jb = XW'(SRC_WIDTH);
            n_j0 = '0;
            n_yo = '0;
            n_ib = YW'(SRC_HEIGHT);
            n_i0 = '0;
            n_y  = '0;
        end else if (i_cmd.advance) begin
            if (xe == XW'(SRC_WIDTH * OUT_SIZE)) begin
                n_xo = '0;
                n_jb = XW'(SRC_WIDTH);
                n_j0 = '0;
                n_y  = r_y + YCW'(1);
                n_yo = ye;
                if (ye >= r_ib) begin
                    n_i0 = r_i0 + OW'(1);
                    n_ib = r_ib + YW'(SRC_HEIGHT);
                end
            end else begin
                n_xo = xe;
                if (xe >= r_jb) begin
                    n_j0 = r_j0 + OW'(1);
                    n_jb = r_jb + XW'(SRC_WIDTH);
                end
            end
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (i_cmd.emit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs     <= 1'b0;
            r_clr    <= '0;
            r_xo     <= '0;
            r_jb     <= XW'(SRC_WIDTH);
            r_j0     <= '0;
            r_yo     <= '0;
            r_ib     <= YW'(SRC_HEIGHT);
            r_i0     <= '0;
            r_y      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_fs <= i_first;
            end
            if (i_cmd.clear_wr) begin
                r_clr <= o_stat.clr_last ? '0 : r_clr + AW'(1);
            end
            r_xo     <= n_xo;
            r_jb     <= n_jb;
            r_j0     <= n_j0;
            r_yo     <= n_yo;
            r_ib     <= n_ib;
            r_i0     <= n_i0;
            r_y      <= n_y;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stat.fs        = r_fs;
    assign o_stat.beyond    = r_y >= YCW'(SRC_HEIGHT);
    assign o_stat.sub_valid = (!i_cmd.k[1] || (row_two && row_ok)) &&
                              (!i_cmd.k[0] || (col_two && col_ok));
    assign o_stat.finish    = col_fin && row_fin;
    assign o_stat.clr_last  = r_clr == AW'(2 * OUT_SIZE - 1);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_gray      = r_ogray;
    assign o_row       = r_orow;
    assign o_col       = r_ocol;
    assign o_last      = r_olast;

    `PGAD_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_ovalid || i_out_ready)
    `PGAD_ASSERT_IMP(a_two_col_in_grid, i_clk, i_rst_n, i_cmd.wr && i_cmd.k[0], col_two && col_ok)
    `PGAD_ASSERT_NXT(a_clr_wrap, i_clk, i_rst_n, i_cmd.clear_wr && o_stat.clr_last, r_clr == '0)
endmodule

@@ rtl/palette_gray_area_downscaler_unit.sv @@
// channel   dir  tdata                                        tuser/tlast
// s_axis    in   [7:0] pixel_code                             tuser: frame_start
// m_axis    out  [7:0] gray_value [14:8] out_row [21:15] out_col  tlast: frame_done
//
// a pixel passes request, luminance, scale and finish check, with up to four cell updates
// in between through the single accumulator ram; a cell that is skipped is only checked
// a pixel that finishes a cell then does a ram read, reciprocal multiply and emit
// a pixel past the end of the frame is taken and dropped
// after reset and on each frame_start the whole accumulator ram is swept
// reset is synchronous, active low; emit stalls only while a full output register is not taken
module palette_gray_area_downscaler_unit #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 210,
    parameter int OUT_SIZE   = 84
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // pixel_code
    input  logic        i_s_axis_tuser,  // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // gray_value, out_row, out_col, zero pad
    output logic        o_m_axis_tlast
);
    import pgad_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [7:0] gray;
    logic [6:0] row;
    logic [6:0] col;

    pgad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_first (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pgad_dp #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .OUT_SIZE   (OUT_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_code      (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_gray      (gray),
        .o_row       (row),
        .o_col       (col),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, col, row, gray};
endmodule

@@ tb/sv/palette_gray_area_downscaler_unit_test.sv @@
`timescale 1ns / 1ps

module palette_gray_area_downscaler_unit_test;
    import pgad_pkg::*;

    localparam int SRC_W    = 160;
    localparam int SRC_H    = 210;
    localparam int GRID     = 84;
    localparam int STALL_MAX = 20000;

    typedef struct {
        logic [7:0] gray;
        logic [6:0] row;
        logic [6:0] col;
        logic       last;
    } t_cell;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;  // pixel_code
    logic        i_s_axis_tuser = 1'b0;  // frame_start
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // gray_value, out_row, out_col, zero pad
    logic        o_m_axis_tlast;         // frame_done

    palette_gray_area_downscaler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // downscaler model state
    int unsigned cell_sum [2][GRID];
    int unsigned src_col;
    int unsigned src_row;
    t_cell       cells_due [$];

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    function automatic int unsigned luma(logic [7:0] code);
        logic [23:0] c;
        if (code[0]) return 0;
        c = PALETTE[code[7:1]];
        return (21 * c[23:16] + 72 * c[15:8] + 7 * c[7:0]) / 100;
    endfunction

    function automatic int unsigned span_overlap(int unsigned a0, int unsigned a1,
                                                 int unsigned b0, int unsigned b1);
        int unsigned lo;
        int unsigned hi;
        lo = a0 > b0 ? a0 : b0;
        hi = a1 < b1 ? a1 : b1;
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic int closing_cell(int unsigned p, int unsigned span);
        int unsigned k;
        k = ((p + 1) * GRID) / span;
        if (k >= 1 && k * span > p * GRID) return k - 1;
        return -1;
    endfunction

    function automatic void predict_pixel(logic [7:0] code, logic fs);
        int unsigned x, y, g, i0, i1, j0, j1, oy, ox;
        int fi, fj;
        t_cell c;
        if (fs) begin
            foreach (cell_sum[a, b]) cell_sum[a][b] = 0;
            src_col = 0;
            src_row = 0;
        end
        if (src_row >= SRC_H) return;
        x = src_col;
        y = src_row;
        src_col++;
        if (src_col >= SRC_W) begin
            src_col = 0;
            src_row++;
        end
        g = luma(code);
        j0 = (x * GRID) / SRC_W;
        j1 = ((x + 1) * GRID - 1) / SRC_W;
        i0 = (y * GRID) / SRC_H;
        i1 = ((y + 1) * GRID - 1) / SRC_H;
        for (int unsigned i = i0; i <= i1 && i < GRID; i++) begin
            oy = span_overlap(y * GRID, (y + 1) * GRID, i * SRC_H, (i + 1) * SRC_H);
            for (int unsigned j = j0; j <= j1 && j < GRID; j++) begin
                ox = span_overlap(x * GRID, (x + 1) * GRID, j * SRC_W, (j + 1) * SRC_W);
                cell_sum[i % 2][j] += g * ox * oy;
            end
        end
        fi = closing_cell(y, SRC_H);
        fj = closing_cell(x, SRC_W);
        if (fi < 0 || fj < 0 || fi >= GRID || fj >= GRID) return;
        c.gray = 8'(cell_sum[fi % 2][fj] / (SRC_W * SRC_H));
        cell_sum[fi % 2][fj] = 0;
        c.row  = 7'(fi);
        c.col  = 7'(fj);
        c.last = (fi == GRID - 1 && fj == GRID - 1);
        cells_due.insert(cells_due.size(), c);
    endfunction

    task automatic send_pixel(input logic [7:0] code, input logic fs);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = code;
        i_s_axis_tuser  = fs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_pixel(code, fs);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver readiness with optional long hold
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell c;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cells_due.size() == 0) begin
                $error("unexpected cell %h", o_m_axis_tdata);
                errors++;
            end else begin
                c = cells_due[0];
                cells_due.delete(0);
                if (o_m_axis_tdata[7:0] !== c.gray) begin
                    $error("gray_value exp %0d got %0d", c.gray, o_m_axis_tdata[7:0]);
                    errors++;
                end
                if (o_m_axis_tdata[14:8] !== c.row) begin
                    $error("out_row exp %0d got %0d", c.row, o_m_axis_tdata[14:8]);
                    errors++;
                end
                if (o_m_axis_tdata[21:15] !== c.col) begin
                    $error("out_col exp %0d got %0d", c.col, o_m_axis_tdata[21:15]);
                    errors++;
                end
                if (o_m_axis_tlast !== c.last) begin
                    $error("frame_done exp %0d got %0d", c.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_extremes;
        logic [7:0] codes [10];
        codes = '{8'd0, 8'd255, 8'd254, 8'd1, 8'd2, 8'd128, 8'd127, 8'd126, 8'd14, 8'd30};
        // pixels before any frame_start count from reset position
        for (int i = 0; i < 10; i++) send_pixel(codes[i], 1'b0);
        // restart mid-row
        send_pixel(8'd254, 1'b1);
        for (int i = 0; i < 12; i++) send_pixel(8'd254 - 8'(2 * i), 1'b0);
        drain();
    endtask

    task automatic test_random_stream(input int n_pix, input bit hold_off);
        send_pixel(8'($urandom_range(255)), 1'b1);
        for (int i = 1; i < n_pix; i++) begin
            if (hold_off && i == 100) rx_hold = 600;
            send_pixel(8'($urandom_range(255)), $urandom_range(399) == 0);
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        tx_idle_pct = 10;
        rx_idle_pct = 81;
        test_random_stream(550, 1'b1);
        tx_idle_pct = 81;
        rx_idle_pct = 10;
        test_random_stream(550, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_stream(550, 1'b0);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
